// File: rtl/swcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcd_pkg
// Shared constants, types and the byte-wise CRC-32 update for the deframer.
// ----------------------------------------------------------------------------
package swcd_pkg;

    localparam int unsigned PACKET_BYTES_DEF = 64;
    localparam int unsigned INDEX_W          = 6;

    localparam logic [7:0]  SYNC0 = 8'hA1;
    localparam logic [7:0]  SYNC1 = 8'hA2;
    localparam logic [7:0]  SYNC2 = 8'hA3;
    localparam logic [7:0]  SYNC3 = 8'hA4;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               last_of_packet;
        logic               crc_good;
    } t_result;

    // Reflected CRC-32, one byte, LSB first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Accumulator after the four header bytes.
    localparam logic [31:0] CRC_HDR =
        crc_byte(crc_byte(crc_byte(crc_byte(CRC_ONES, SYNC0), SYNC1), SYNC2), SYNC3);

endpackage

// File: rtl/swcd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcd_in_stage
// Input register: holds one received byte until the core consumes it.
// ----------------------------------------------------------------------------
module swcd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_in_ready = !r_valid || i_advance;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_data_byte;
        end
    end

endmodule

// File: rtl/swcd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcd_core
// Header hunt, packet byte count, CRC accumulation and check.
// ----------------------------------------------------------------------------
module swcd_core
    import swcd_pkg::*;
#(
    parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_advance,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int unsigned CNT_W =
        ($clog2(PACKET_BYTES) < INDEX_W) ? INDEX_W : $clog2(PACKET_BYTES);
    localparam logic [CNT_W-1:0] CRC_START = CNT_W'(PACKET_BYTES - 4);
    localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(PACKET_BYTES - 1);
    localparam logic [CNT_W-1:0] FIRST_IDX = CNT_W'(4);

    logic [23:0]      r_win,   n_win;
    logic             r_inp,   n_inp;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic [31:0]      r_crc,   n_crc;
    logic [31:0]      r_rx,    n_rx;

    logic [31:0]      rx_next;
    logic             last;

    assign rx_next = {i_byte, r_rx[31:8]};
    assign last    = (r_cnt >= LAST_IDX);

    always_comb begin
        n_win       = r_win;
        n_inp       = r_inp;
        n_cnt       = r_cnt;
        n_crc       = r_crc;
        n_rx        = r_rx;
        o_res_valid = 1'b0;
        o_res.out_byte       = i_byte;
        o_res.byte_index     = r_cnt[INDEX_W-1:0];
        o_res.last_of_packet = last;
        o_res.crc_good       = 1'b0;
        if (!r_inp) begin
            if (r_win == {SYNC0, SYNC1, SYNC2} && i_byte == SYNC3) begin
                n_crc = CRC_HDR;
                n_rx  = 32'd0;
                n_cnt = FIRST_IDX;
                n_inp = 1'b1;
                n_win = 24'd0;
            end else begin
                n_win = {r_win[15:0], i_byte};
            end
        end else begin
            o_res_valid = 1'b1;
            if (r_cnt < CRC_START) begin
                n_crc = crc_byte(r_crc, i_byte);
            end else begin
                n_rx = rx_next;
            end
            if (last) begin
                o_res.crc_good = (rx_next == ~r_crc);
                n_win = 24'd0;
                n_inp = 1'b0;
                n_cnt = '0;
                n_crc = CRC_ONES;
                n_rx  = 32'd0;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= 24'd0;
            r_inp <= 1'b0;
            r_cnt <= '0;
            r_crc <= CRC_ONES;
            r_rx  <= 32'd0;
        end else if (i_advance) begin
            r_win <= n_win;
            r_inp <= n_inp;
            r_cnt <= n_cnt;
            r_crc <= n_crc;
            r_rx  <= n_rx;
        end
    end

endmodule

// File: rtl/swcd_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcd_out_stage
// Result register: holds one result request until the receiver takes it.
// ----------------------------------------------------------------------------
module swcd_out_stage
    import swcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output logic    o_free,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// File: rtl/sync_word_crc32_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_word_crc32_deframer
// Hunts a byte stream for the sync header A1 A2 A3 A4, then passes the rest
// of a PACKET_BYTES packet out byte by byte with its index. The last byte
// carries the check of the trailing little-endian CRC-32 over header and data.
//
// Input channel: i_data_byte with i_in_valid / o_in_ready.
// Output channel: o_out_byte, o_byte_index, o_last_of_packet, o_crc_good with
// o_out_valid / i_out_ready. Header and hunted bytes give no output request.
// A result passes through the input register, then the result register; the
// CRC byte update and header compare sit between the two registers.
// Throughput: one byte per cycle while the result register is free to take
// a new request, that is, while the receiver does not stall.
// When the receiver stalls, the result register holds its request and the
// input register keeps at most one more byte; once it is full, o_in_ready
// drops until the receiver takes the waiting request.
// Reset (synchronous, active low) empties both registers and restarts the
// hunt with a cleared window; the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module sync_word_crc32_deframer
    import swcd_pkg::*;
#(
    parameter int unsigned PACKET_BYTES = PACKET_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_out_byte,
    output logic [INDEX_W-1:0] o_byte_index,
    output logic               o_last_of_packet,
    output logic               o_crc_good
);

    logic       s_valid;
    logic [7:0] s_byte;
    logic       out_free;
    logic       advance;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    assign advance = s_valid && out_free;

    swcd_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_advance   (advance),
        .o_valid     (s_valid),
        .o_byte      (s_byte)
    );

    swcd_core #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_byte      (s_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    swcd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance && res_valid),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_free      (out_free),
        .o_res       (out_res)
    );

    assign o_out_byte       = out_res.out_byte;
    assign o_byte_index     = out_res.byte_index;
    assign o_last_of_packet = out_res.last_of_packet;
    assign o_crc_good       = out_res.crc_good;

endmodule

// File: tb/swcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcd_checker
// Watches both request channels of the deframer. Tracks hunt and packet state
// for every accepted input byte, queues the result each payload byte should
// give, and compares every accepted output request against the oldest one.
// ----------------------------------------------------------------------------
module swcd_checker
    import swcd_pkg::*;
#(
    parameter int unsigned PKT_LEN = PACKET_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [7:0]         i_out_byte,
    input  logic [INDEX_W-1:0] i_byte_index,
    input  logic               i_last_of_packet,
    input  logic               i_crc_good,
    output int                 o_err_count,
    output int                 o_pending
);

    logic [23:0] hunt_win;
    logic        framing;
    int unsigned next_idx;
    logic [31:0] crc_run;
    logic [31:0] crc_rx;
    t_result     frame_q[$];
    int          err_cnt = 0;
    int          pending_cnt = 0;

    assign o_err_count = err_cnt;
    assign o_pending   = pending_cnt;

    // bit-serial reflected CRC-32 update, LSB of the byte first
    function automatic logic [31:0] crc32_feed(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        logic        fb;
        r = acc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic restart_hunt();
        hunt_win = '0;
        framing  = 1'b0;
        next_idx = 0;
        crc_run  = CRC_ONES;
        crc_rx   = '0;
    endtask

    task automatic frame_byte(input logic [7:0] b);
        t_result     r;
        int unsigned crc_at;
        crc_at = PKT_LEN - 4;
        if (!framing) begin
            if (hunt_win == {SYNC0, SYNC1, SYNC2} && b == SYNC3) begin
                crc_run  = crc32_feed(crc32_feed(crc32_feed(crc32_feed(CRC_ONES, SYNC0),
                                      SYNC1), SYNC2), SYNC3);
                crc_rx   = '0;
                next_idx = 4;
                framing  = 1'b1;
                hunt_win = '0;
            end else begin
                hunt_win = {hunt_win[15:0], b};
            end
        end else begin
            if (next_idx < crc_at) begin
                crc_run = crc32_feed(crc_run, b);
            end else begin
                crc_rx = crc_rx | ({24'd0, b} << (8 * ((next_idx - crc_at) % 4)));
            end
            r.out_byte       = b;
            r.byte_index     = INDEX_W'(next_idx);
            r.last_of_packet = (next_idx >= PKT_LEN - 1);
            r.crc_good       = r.last_of_packet && (crc_rx == ~crc_run);
            frame_q.push_back(r);
            if (r.last_of_packet) begin
                restart_hunt();
            end else begin
                next_idx++;
            end
        end
    endtask

    task automatic note_fail(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%t ERROR: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            restart_hunt();
            frame_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                frame_byte(i_data_byte);
            end
            if (i_out_valid && i_out_ready) begin
                got.out_byte       = i_out_byte;
                got.byte_index     = i_byte_index;
                got.last_of_packet = i_last_of_packet;
                got.crc_good       = i_crc_good;
                if (frame_q.size() == 0) begin
                    note_fail($sformatf("unexpected result byte %02h idx %0d last %0b good %0b",
                                        got.out_byte, got.byte_index, got.last_of_packet,
                                        got.crc_good));
                end else begin
                    want = frame_q.pop_front();
                    if (got !== want) begin
                        note_fail($sformatf({"expected byte %02h idx %0d last %0b good %0b, ",
                                             "got byte %02h idx %0d last %0b good %0b"},
                                            want.out_byte, want.byte_index,
                                            want.last_of_packet, want.crc_good,
                                            got.out_byte, got.byte_index,
                                            got.last_of_packet, got.crc_good));
                    end
                end
            end
        end
        pending_cnt = frame_q.size();
    end

endmodule

// File: tb/tb_sync_word_crc32_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_word_crc32_deframer
// Drives the deframer with near-miss and overlapping sync headers, packets of
// random, all-zero and all-ones payload with good or corrupted CRC, embedded
// sync words and noise, under several sender/receiver idling mixes and two
// long receiver hold-offs. Checking is done by swcd_checker.
// ----------------------------------------------------------------------------
module tb_sync_word_crc32_deframer;
    import swcd_pkg::*;

    localparam int PKT_LEN     = PACKET_BYTES_DEF;
    localparam int PHASE_ITEMS = 280;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZEROS  = 1;
    localparam int FILL_ONES   = 2;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [7:0]         i_data_byte;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [7:0]         o_out_byte;
    logic [INDEX_W-1:0] o_byte_index;
    logic               o_last_of_packet;
    logic               o_crc_good;

    int err_count;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_start = 1'b0;
    int bytes_sent = 0;

    sync_word_crc32_deframer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_index    (o_byte_index),
        .o_last_of_packet(o_last_of_packet),
        .o_crc_good      (o_crc_good)
    );

    swcd_checker #(.PKT_LEN(PKT_LEN)) u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out_byte      (o_out_byte),
        .i_byte_index    (o_byte_index),
        .i_last_of_packet(o_last_of_packet),
        .i_crc_good      (o_crc_good),
        .o_err_count     (err_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_start) begin
                hold_start = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_packet(input bit corrupt, input bit embed_sync, input int fill);
        logic [7:0]  pkt [PKT_LEN];
        logic [31:0] c;
        int          at;
        pkt[0] = SYNC0;
        pkt[1] = SYNC1;
        pkt[2] = SYNC2;
        pkt[3] = SYNC3;
        for (int i = 4; i < PKT_LEN - 4; i++) begin
            case (fill)
                FILL_ZEROS: pkt[i] = 8'h00;
                FILL_ONES:  pkt[i] = 8'hFF;
                default:    pkt[i] = 8'($urandom);
            endcase
        end
        if (embed_sync) begin
            at = $urandom_range(4, PKT_LEN - 8);
            pkt[at]     = SYNC0;
            pkt[at + 1] = SYNC1;
            pkt[at + 2] = SYNC2;
            pkt[at + 3] = SYNC3;
        end
        c = CRC_ONES;
        for (int i = 0; i < PKT_LEN - 4; i++) begin
            c = c ^ {24'd0, pkt[i]};
            for (int k = 0; k < 8; k++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
        end
        c = ~c;
        for (int j = 0; j < 4; j++) begin
            pkt[PKT_LEN - 4 + j] = c[8*j +: 8];
        end
        if (corrupt) begin
            at = $urandom_range(4, PKT_LEN - 1);
            pkt[at] = pkt[at] ^ (8'h01 << $urandom_range(7));
        end
        for (int i = 0; i < PKT_LEN; i++) begin
            send_byte(pkt[i]);
        end
    endtask

    // stray bytes and broken headers between packets
    task automatic send_noise();
        int   n;
        logic [7:0] b;
        case ($urandom_range(2))
            0: begin
                n = $urandom_range(1, 12);
                repeat (n) send_byte(8'($urandom));
            end
            1: begin
                send_byte(SYNC0);
                send_byte(SYNC1);
                send_byte(SYNC2);
                do b = 8'($urandom); while (b == SYNC3);
                send_byte(b);
            end
            default: begin
                send_byte(SYNC0);
                send_byte(SYNC1);
            end
        endcase
    endtask

    int phase_idle  [4] = '{0, 60, 0, 20};
    int phase_stall [4] = '{0, 0, 60, 20};

    initial begin
        int goal;
        int pick;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_data_byte = 8'h00;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero window after reset, near misses, wrong order, overlap
        send_byte(SYNC3);
        send_byte(SYNC0);
        send_byte(SYNC1);
        send_byte(SYNC2);
        send_byte(8'hA5);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC2);
        send_byte(SYNC1);
        send_byte(SYNC0);
        send_byte(SYNC3);
        send_byte(SYNC0);
        send_byte(SYNC1);
        send_packet(1'b0, 1'b1, FILL_ZEROS);
        send_packet(1'b0, 1'b0, FILL_ONES);
        send_packet(1'b1, 1'b0, FILL_RANDOM);
        send_packet(1'b0, 1'b1, FILL_RANDOM);

        for (int p = 0; p < 4; p++) begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            goal      = bytes_sent + PHASE_ITEMS;
            if (p == 0 || p == 3) begin
                hold_start = 1'b1;
            end
            while (bytes_sent < goal) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    send_packet(1'b0, ($urandom_range(9) == 0), FILL_RANDOM);
                end else if (pick < 80) begin
                    send_packet(1'b1, ($urandom_range(9) == 0), FILL_RANDOM);
                end else begin
                    send_noise();
                end
            end
        end

        i_in_valid <= 1'b0;
        stall_pct   = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
